FILE: rtl/batch_integer_sorter_assert.svh
// Assertion macros for the batch integer sorter.
// Each macro expands to one labeled concurrent assertion, clocked on clk
// and disabled while rst_n is low.
`ifndef BATCH_INTEGER_SORTER_ASSERT_SVH
`define BATCH_INTEGER_SORTER_ASSERT_SVH

// Same-cycle implication
`define BIS_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("batch_integer_sorter: same-cycle check failed");

// Next-cycle implication
`define BIS_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("batch_integer_sorter: next-cycle check failed");

`endif

FILE: rtl/bis_pkg.sv
// ---------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the batch integer sorter.
// ---------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

    // Default depth of the cell chain
    localparam int BIS_MAX_ELEMENTS = 64;

    // Element width
    localparam int BIS_DATA_W = 32;

    typedef logic signed [BIS_DATA_W-1:0] bis_data_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic insert;     // insert the broadcast value this cycle
        logic drain;      // shift all cells one place toward cell 0
        logic descending; // sort order: 1 puts larger values first
    } bis_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/batch_integer_sorter.sv
// ---------------------------------------------------------------------------
// batch_integer_sorter
// Collects a batch of signed 32-bit integers and streams it back sorted.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one element per transaction, s_tlast on the final
//   element of the batch. While loading, one element is taken every cycle;
//   a chain of MAX_ELEMENTS cells keeps the batch sorted as it arrives.
//   Elements past MAX_ELEMENTS are dropped and the batch is flagged.
//   Output stream (m_*): the sorted batch, m_tlast on its final element,
//   m_tuser set on every element of a truncated batch. The first result is
//   offered in the cycle after the last input is taken; then one result per
//   cycle while m_tready is high. The chain shifts toward cell 0 only when a
//   result is taken; a stalled receiver freezes it.
//   s_tready is low from the last input until the final result is taken.
//   cfg_wr_en/cfg_wr_data write the order bit: 0 ascending, 1 descending.
//   Write it only between batches.
//   Reset empties the chain, clears the truncation flag and selects
//   ascending order.
// ---------------------------------------------------------------------------
`default_nettype none

module batch_integer_sorter #(
    parameter int MAX_ELEMENTS = bis_pkg::BIS_MAX_ELEMENTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,   // descending_order
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // [31:0] in_value
    input  wire logic        s_tlast,       // in_last
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [31:0] out_value
    output logic             m_tlast,       // out_last
    output logic             m_tuser        // [0] truncated
);
    import bis_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    state_t    state_reg;
    logic      overflow_reg;
    logic      descending_reg;

    bis_ctrl_t ctrl;
    bis_data_t new_value;
    bis_data_t cell_value [MAX_ELEMENTS];
    logic      cell_valid [MAX_ELEMENTS];
    logic      cell_take  [MAX_ELEMENTS];

    logic      in_fire;
    logic      out_fire;
    logic      chain_full;

    assign new_value  = bis_data_t'(s_tdata);
    assign s_tready   = (state_reg == ST_LOAD);
    assign in_fire    = s_tvalid && s_tready;
    assign out_fire   = m_tvalid && m_tready;
    assign chain_full = cell_valid[MAX_ELEMENTS-1];

    // Control broadcast
    always_comb
    begin
        ctrl.insert     = in_fire && !chain_full;
        ctrl.drain      = out_fire;
        ctrl.descending = descending_reg;
    end

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++)
        begin : g_cell
            bis_data_t prev_value;
            logic      prev_valid;
            logic      prev_take;
            bis_data_t next_value;
            logic      next_valid;

            if (gi == 0)
            begin : g_first
                assign prev_value = new_value;
                assign prev_valid = 1'b1;
                assign prev_take  = 1'b0;
            end
            else
            begin : g_inner_prev
                assign prev_value = cell_value[gi-1];
                assign prev_valid = cell_valid[gi-1];
                assign prev_take  = cell_take[gi-1];
            end

            if (gi == MAX_ELEMENTS - 1)
            begin : g_last
                assign next_value = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner_next
                assign next_value = cell_value[gi+1];
                assign next_valid = cell_valid[gi+1];
            end

            bis_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (new_value),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .prev_take  (prev_take),
                .next_value (next_value),
                .next_valid (next_valid),
                .value      (cell_value[gi]),
                .valid      (cell_valid[gi]),
                .take       (cell_take[gi])
            );
        end
    endgenerate

    // Output stream: data from cell 0, last from cell 1, user from the truncation flag
    assign m_tvalid = (state_reg == ST_DRAIN) && cell_valid[0];
    assign m_tdata  = cell_value[0];
    assign m_tlast  = !cell_valid[1];
    assign m_tuser  = overflow_reg;

    // Order register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            descending_reg <= cfg_wr_data;
        end
    end

    // Batch state machine and truncation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (chain_full)
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (s_tlast)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (out_fire && m_tlast)
                    begin
                        state_reg    <= ST_LOAD;
                        overflow_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Checks
`include "batch_integer_sorter_assert.svh"

    `BIS_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready)
    `BIS_ASSERT_NEXT(a_last_in_drains, in_fire && s_tlast, m_tvalid && !s_tready)
    `BIS_ASSERT_NEXT(a_last_out_loads, out_fire && m_tlast, s_tready && !m_tuser)
    `BIS_ASSERT_NEXT(a_drop_flags, in_fire && chain_full, m_tuser || s_tready)

endmodule

`default_nettype wire

FILE: rtl/bis_cell.sv
// ---------------------------------------------------------------------------
// bis_cell
// One cell of the insertion chain: holds one element and its valid bit,
// takes the new element or its lower neighbor's element on insert, and its
// upper neighbor's element on drain.
// ---------------------------------------------------------------------------
`default_nettype none

module bis_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bis_pkg::bis_ctrl_t ctrl,
    input  wire bis_pkg::bis_data_t new_value,   // broadcast insert value
    input  wire bis_pkg::bis_data_t prev_value,  // neighbor toward cell 0
    input  wire logic               prev_valid,
    input  wire logic               prev_take,
    input  wire bis_pkg::bis_data_t next_value,  // neighbor away from cell 0
    input  wire logic               next_valid,
    output bis_pkg::bis_data_t      value,
    output logic                    valid,
    output logic                    take
);
    import bis_pkg::*;

    bis_data_t value_reg;
    bis_data_t value_next;
    logic      valid_reg;
    logic      valid_next;
    logic      goes_before;

    // New value belongs in front of the held one
    always_comb
    begin
        if (ctrl.descending)
        begin
            goes_before = (new_value > value_reg);
        end
        else
        begin
            goes_before = (new_value < value_reg);
        end
    end

    assign take = !valid_reg || goes_before;

    // Next-state selection
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.drain)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.insert && take)
        begin
            value_next = prev_take ? prev_value : new_value;
            valid_next = valid_reg | prev_valid;
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Element payload, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire
